@@ hdl/ant_pkg.sv @@
// ----------------------------------------------------------------------------
// Amicable number test package
// Shared widths for the amicable number test block.
// ----------------------------------------------------------------------------
package ant_pkg;
    localparam int NUMBER_WIDTH = 32;
    localparam int SUM_WIDTH    = 35;
    localparam int ROOT_WIDTH   = NUMBER_WIDTH / 2 + 1;
    localparam int DCNT_WIDTH   = $clog2(SUM_WIDTH + 1);
endpackage

@@ hdl/amicable_number_test_top.sv @@
// ----------------------------------------------------------------------------
// Amicable number test
// Sums proper divisors by trial division and tests for an amicable pair.
// ----------------------------------------------------------------------------
// Channel | Direction | Payload
// s_axis  | in        | tdata[31:0] candidate
// m_axis  | out       | tdata[34:0] divisor_sum, tuser[0] is_amicable
// cfg     | in        | i_cfg_data[31:0] search_limit
// Each trial divisor runs one serial division, and an item costs at most two
// divisor sums, one for the candidate and one for its sum.
// Reset clears the limit and the sequencer; no item is taken while busy.
// A result waits in the output register; the next item is taken meanwhile.
// ----------------------------------------------------------------------------
module amicable_number_test_top
    import ant_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    s_axis_tvalid,
    output logic                    s_axis_tready,
    input  logic [31:0]             s_axis_tdata,   // candidate
    output logic                    m_axis_tvalid,
    input  logic                    m_axis_tready,
    output logic [39:0]             m_axis_tdata,   // divisor_sum, zero fill
    output logic [0:0]              m_axis_tuser,   // is_amicable
    input  logic                    i_cfg_valid,
    output logic                    o_cfg_ready,
    input  logic [31:0]             i_cfg_data      // search_limit
);
    typedef enum logic [2:0] {S_IDLE, S_CHECK, S_DIV, S_WAIT, S_DONE} t_state;

    t_state                r_state;
    logic                  r_second;
    logic [NUMBER_WIDTH-1:0] r_limit;
    logic [NUMBER_WIDTH-1:0] r_cand;
    logic [SUM_WIDTH-1:0]  r_n;
    logic [ROOT_WIDTH-1:0] r_i;
    logic [SUM_WIDTH-1:0]  r_sum;
    logic [SUM_WIDTH-1:0]  r_first;
    logic [SUM_WIDTH-1:0]  r_rsum;
    logic                  r_rflag;
    logic                  r_ovalid;
    logic [SUM_WIDTH-1:0]  r_osum;
    logic                  r_oflag;
    logic                  r_start;
    logic                  w_done;
    logic [SUM_WIDTH-1:0]  w_quo;
    logic [SUM_WIDTH-1:0]  w_rem;
    logic [2*ROOT_WIDTH-1:0] w_sq;
    logic                  w_fin;
    logic [SUM_WIDTH-1:0]  w_tot;
    logic                  w_load;

    ant_divider u_div (
        .i_clk, .i_rst_n, .i_start(r_start), .i_dividend(r_n), .i_divisor(r_i),
        .o_done(w_done), .o_quotient(w_quo), .o_remainder(w_rem)
    );

    assign w_sq = r_i * r_i;
    assign s_axis_tready = (r_state == S_IDLE);
    assign o_cfg_ready   = 1'b1;
    assign w_load        = (r_state == S_DONE) && (!r_ovalid || m_axis_tready);

    always_comb begin
        w_fin = 1'b0;
        w_tot = r_sum;
        if (r_n <= SUM_WIDTH'(1)) begin
            w_fin = 1'b1;
            w_tot = '0;
        end else if ({{(SUM_WIDTH+1-2*ROOT_WIDTH){1'b0}}, w_sq} > {1'b0, r_n}) begin
            w_fin = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_limit  <= '0;
            r_ovalid <= 1'b0;
            r_start  <= 1'b0;
            r_second <= 1'b0;
            r_i      <= '0;
            r_sum    <= '0;
            r_first  <= '0;
            r_rsum   <= '0;
            r_rflag  <= 1'b0;
            r_osum   <= '0;
            r_oflag  <= 1'b0;
        end else begin
            r_start <= (r_state == S_CHECK) && !w_fin;
            if (i_cfg_valid) r_limit <= i_cfg_data[NUMBER_WIDTH-1:0];
            if (w_load) begin
                r_ovalid <= 1'b1;
            end else if (m_axis_tready) begin
                r_ovalid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (s_axis_tvalid && s_axis_tready) begin
                        r_cand   <= s_axis_tdata[NUMBER_WIDTH-1:0];
                        r_n      <= SUM_WIDTH'(s_axis_tdata[NUMBER_WIDTH-1:0]);
                        r_i      <= ROOT_WIDTH'(2);
                        r_sum    <= SUM_WIDTH'(1);
                        r_second <= 1'b0;
                        r_state  <= S_CHECK;
                    end
                end
                S_CHECK: begin
                    if (w_fin) begin
                        if (!r_second) begin
                            r_first <= w_tot;
                            if (r_cand >= NUMBER_WIDTH'(2) && r_cand < r_limit &&
                                w_tot > SUM_WIDTH'(r_cand) &&
                                w_tot <= SUM_WIDTH'(r_limit)) begin
                                r_second <= 1'b1;
                                r_n      <= w_tot;
                                r_i      <= ROOT_WIDTH'(2);
                                r_sum    <= SUM_WIDTH'(1);
                            end else begin
                                r_rsum  <= w_tot;
                                r_rflag <= 1'b0;
                                r_state <= S_DONE;
                            end
                        end else begin
                            r_rsum  <= r_first;
                            r_rflag <= (w_tot == SUM_WIDTH'(r_cand));
                            r_state <= S_DONE;
                        end
                    end else begin
                        r_state <= S_DIV;
                    end
                end
                S_DIV: r_state <= S_WAIT;
                S_WAIT: begin
                    if (w_done) begin
                        if (w_rem == '0) begin
                            if (w_quo != SUM_WIDTH'(r_i))
                                r_sum <= r_sum + SUM_WIDTH'(r_i) + w_quo;
                            else
                                r_sum <= r_sum + SUM_WIDTH'(r_i);
                        end
                        r_i     <= r_i + 1'b1;
                        r_state <= S_CHECK;
                    end
                end
                S_DONE: begin
                    if (w_load) begin
                        r_osum  <= r_rsum;
                        r_oflag <= r_rflag;
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = {5'd0, r_osum};
    assign m_axis_tuser  = r_oflag;

    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> !s_axis_tready) else $error("accept while busy");
    a_hold_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ovalid && !m_axis_tready) |=>
        (r_ovalid && $stable(r_osum) && $stable(r_oflag))) else $error("result lost");
    a_start_once: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_start |=> !r_start) else $error("double start");
endmodule

@@ hdl/ant_divider.sv @@
// ----------------------------------------------------------------------------
// Serial divider
// Restoring division of a sum-width dividend by a root-width divisor, one
// quotient bit per cycle.
// ----------------------------------------------------------------------------
module ant_divider
    import ant_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    input  logic [SUM_WIDTH-1:0]  i_dividend,
    input  logic [ROOT_WIDTH-1:0] i_divisor,
    output logic                  o_done,
    output logic [SUM_WIDTH-1:0]  o_quotient,
    output logic [SUM_WIDTH-1:0]  o_remainder
);
    logic [SUM_WIDTH-1:0]  r_quo;
    logic [SUM_WIDTH:0]    r_rem;
    logic [ROOT_WIDTH-1:0] r_div;
    logic [DCNT_WIDTH-1:0] r_cnt;
    logic                  r_busy;
    logic                  r_done;
    logic [SUM_WIDTH:0]    w_trial;
    logic [SUM_WIDTH:0]    w_sub;

    assign w_trial = {r_rem[SUM_WIDTH-1:0], r_quo[SUM_WIDTH-1]};
    assign w_sub   = w_trial - {{(SUM_WIDTH+1-ROOT_WIDTH){1'b0}}, r_div};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= DCNT_WIDTH'(SUM_WIDTH);
                r_quo  <= i_dividend;
                r_rem  <= '0;
                r_div  <= i_divisor;
            end else if (r_busy) begin
                if (!w_sub[SUM_WIDTH]) begin
                    r_rem <= w_sub;
                    r_quo <= {r_quo[SUM_WIDTH-2:0], 1'b1};
                end else begin
                    r_rem <= w_trial;
                    r_quo <= {r_quo[SUM_WIDTH-2:0], 1'b0};
                end
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == DCNT_WIDTH'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done      = r_done;
    assign o_quotient  = r_quo;
    assign o_remainder = r_rem[SUM_WIDTH-1:0];
endmodule

@@ test/amicable_number_checker.sv @@
// ----------------------------------------------------------------------------
// Amicable number checker
// Watches the candidate, result and limit channels of the amicable number
// test block. It works out the proper divisor sum and the amicable flag of
// every accepted candidate and compares them with the results in order.
// ----------------------------------------------------------------------------
module amicable_number_checker
    import ant_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cand_valid,
    input  logic        i_cand_ready,
    input  logic [31:0] i_cand_data,
    input  logic        i_res_valid,
    input  logic        i_res_ready,
    input  logic [39:0] i_res_data,
    input  logic [0:0]  i_res_user,
    input  logic        i_cfg_valid,
    input  logic        i_cfg_ready,
    input  logic [31:0] i_cfg_data,
    output int          o_mismatches,
    output int          o_pending,
    output int          o_results,
    output int          o_pairs
);
    typedef struct {
        logic [31:0]          candidate;
        logic [SUM_WIDTH-1:0] divisor_sum;
        logic                 is_amicable;
    } t_sum_result;

    t_sum_result              expected_sums[$];
    logic [NUMBER_WIDTH-1:0]  search_limit;

    function automatic longint unsigned divisor_total(longint unsigned n);
        longint unsigned total;
        longint unsigned i;
        if (n <= 1) begin
            return 0;
        end
        total = 1;
        for (i = 2; i * i <= n; i++) begin
            if (n % i == 0) begin
                total += i;
                if (n / i != i) begin
                    total += n / i;
                end
            end
        end
        return total & ((64'd1 << SUM_WIDTH) - 1);
    endfunction

    function automatic t_sum_result predict_sum(logic [31:0] cand, logic [31:0] lim);
        t_sum_result     r;
        longint unsigned a;
        longint unsigned b;
        longint unsigned n;
        a = cand[NUMBER_WIDTH-1:0];
        n = lim[NUMBER_WIDTH-1:0];
        b = divisor_total(a);
        r.candidate   = cand;
        r.divisor_sum = b[SUM_WIDTH-1:0];
        r.is_amicable = (a >= 2 && a < n && b > a && b <= n) ? (divisor_total(b) == a) : 1'b0;
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_sum_result want;
        if (!i_rst_n) begin
            search_limit <= '0;
            expected_sums.delete();
            o_mismatches <= 0;
            o_pending    <= 0;
            o_results    <= 0;
            o_pairs      <= 0;
        end else begin
            if (i_res_valid && i_res_ready) begin
                o_results <= o_results + 1;
                if (expected_sums.size() == 0) begin
                    o_mismatches <= o_mismatches + 1;
                    if (o_mismatches < 10) begin
                        $display("Unexpected result: sum %0d flag %0d",
                                 i_res_data[SUM_WIDTH-1:0], i_res_user[0]);
                    end
                end else begin
                    want = expected_sums.pop_front();
                    if (want.is_amicable) begin
                        o_pairs <= o_pairs + 1;
                    end
                    if (i_res_data !== {{(40-SUM_WIDTH){1'b0}}, want.divisor_sum} ||
                        i_res_user[0] !== want.is_amicable) begin
                        o_mismatches <= o_mismatches + 1;
                        if (o_mismatches < 10) begin
                            $display({"Mismatch for candidate %0d: expected sum %0d ",
                                      "flag %0d, got data %0d flag %0d"},
                                     want.candidate, want.divisor_sum, want.is_amicable,
                                     i_res_data, i_res_user[0]);
                        end
                    end
                end
            end
            if (i_cand_valid && i_cand_ready) begin
                expected_sums.insert(expected_sums.size(),
                                     predict_sum(i_cand_data, search_limit));
            end
            if (i_cfg_valid && i_cfg_ready) begin
                search_limit <= i_cfg_data[NUMBER_WIDTH-1:0];
            end
            o_pending <= expected_sums.size();
        end
    end
endmodule

@@ test/amicable_number_test_top_test.sv @@
// ----------------------------------------------------------------------------
// Amicable number test testbench
// Drives candidates through several search limits, first a directed set of
// perfect numbers, pairs and extremes, then random candidates that are mostly
// members of known amicable pairs, with random idling on both channels.
// ----------------------------------------------------------------------------
module amicable_number_test_top_test;
    import ant_pkg::*;

    logic        i_clk;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata;   // candidate
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [39:0] m_axis_tdata;   // divisor_sum, zero fill
    logic [0:0]  m_axis_tuser;   // is_amicable
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [31:0] i_cfg_data;     // search_limit
    int          mismatches;
    int          pending;
    int          results;
    int          pairs;
    logic        quiet;
    int          ready_burst = 0;

    localparam logic [31:0] PAIR_MEMBERS [16] = '{220, 284, 1184, 1210, 2620, 2924, 5020,
        5564, 6232, 6368, 10744, 10856, 12285, 14595, 17296, 18416};

    amicable_number_test_top dut (.*);

    amicable_number_checker checker_inst (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cand_valid (s_axis_tvalid),
        .i_cand_ready (s_axis_tready),
        .i_cand_data  (s_axis_tdata),
        .i_res_valid  (m_axis_tvalid),
        .i_res_ready  (m_axis_tready),
        .i_res_data   (m_axis_tdata),
        .i_res_user   (m_axis_tuser),
        .i_cfg_valid  (i_cfg_valid),
        .i_cfg_ready  (o_cfg_ready),
        .i_cfg_data   (i_cfg_data),
        .o_mismatches (mismatches),
        .o_pending    (pending),
        .o_results    (results),
        .o_pairs      (pairs)
    );

    initial i_clk = 1'b0;
    always #6 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        if (quiet) begin
            m_axis_tready <= 1'b1;
        end else if (ready_burst > 0) begin
            ready_burst   <= ready_burst - 1;
        end else if ($urandom_range(0, 3) == 0) begin
            m_axis_tready <= ~m_axis_tready;
            ready_burst   <= $urandom_range(1, 19);
        end
    end

    task automatic send_candidate(input logic [31:0] value);
        if (!quiet && $urandom_range(0, 2) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= value;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
    endtask

    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
    endtask

    task automatic write_limit(input logic [31:0] value);
        drain_results();
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= value;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    initial begin
        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        i_cfg_valid   = 1'b0;
        i_cfg_data    = '0;
        quiet         = 1'b0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // The limit is still zero after reset, so no pair can qualify.
        send_candidate(0);
        send_candidate(1);
        send_candidate(220);
        send_candidate(2);
        write_limit(32'hFFFF_FFFF);
        send_candidate(32'hFFFF_FFFF);
        send_candidate(6);
        send_candidate(28);
        send_candidate(496);
        send_candidate(8128);
        send_candidate(220);
        send_candidate(284);
        send_candidate(1184);
        send_candidate(12);
        send_candidate(1_048_573);
        send_candidate(1_048_576);
        write_limit(1);
        send_candidate(220);
        send_candidate(1);
        write_limit(250);
        send_candidate(220);
        send_candidate(249);
        send_candidate(12);
        write_limit(284);
        send_candidate(220);
        send_candidate(283);

        write_limit(20000);
        for (int k = 0; k < 80; k++) begin
            if (k == 64) begin
                drain_results();
                quiet = 1'b1;
            end
            if ($urandom_range(0, 9) < 6) begin
                send_candidate(PAIR_MEMBERS[$urandom_range(0, 15)]);
            end else begin
                send_candidate($urandom_range(0, 21000));
            end
        end
        drain_results();
        repeat (100) @(posedge i_clk);

        $display("Checked %0d results under six search limits, %0d of them amicable pairs.",
                 results, pairs);
        if (mismatches == 0) begin
            $display("amicable_number_test_top_test passed");
        end else begin
            $display("amicable_number_test_top_test failed");
        end
        $finish;
    end

    initial begin
        #(12 * 40_000_000);
        $display("amicable_number_test_top_test failed");
        $finish;
    end
endmodule
